FILE: rtl/core/lefcr_pkg.sv
// Shared types, constants and state encodings for the LoG edge filter.
// No dependencies; lefcr_front, lefcr_back and the top level import this package.
package lefcr_pkg;

  // Default maximum frame geometry; the width also sizes the line buffers.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Configuration register file.
  localparam int CFG_DATA_W = 12;
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;
  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  // Item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Luma conversion: Y = 4096 + floor((2336*N + 5312) / 10625), which equals
  // 4096 + floor((N*56064 + 127500) / 255000). The division is a multiply by
  // the reciprocal of 10625 scaled by 2^44, exact for every numerator in range.
  localparam logic [17:0] COEF_B      = 18'd114;
  localparam logic [17:0] COEF_G      = 18'd587;
  localparam logic [17:0] COEF_R      = 18'd299;
  localparam logic [29:0] LUMA_SCALE  = 30'd2336;
  localparam logic [29:0] LUMA_ROUND  = 30'd5312;
  localparam logic [30:0] LUMA_RECIP  = 31'd1655735158;
  localparam int          LUMA_SHIFT  = 44;
  localparam logic [15:0] LUMA_OFFSET = 16'd4096;

  // Kernel magnitudes in Q2.14; corners are positive, edges and center negative.
  localparam logic [13:0] K_CORNER     = 14'd8058;
  localparam logic [10:0] K_EDGE_MAG   = 11'd1880;
  localparam logic [14:0] K_CENTER_MAG = 15'd24712;

  // Item passed from the front end to the back end.
  typedef struct packed {
    logic        kind;
    logic [23:0] color;
    logic [15:0] luma;
  } pix_item_t;

  // Result item waiting in the output queue.
  typedef struct packed {
    logic       frame_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  // Raw frame geometry registers.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
  } frame_cfg_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SCALE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_UPDATE,
    BE_SUM,
    BE_MUL,
    BE_OUT
  } be_state_t;

endpackage

FILE: rtl/core/lefcr_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module lefcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/lefcr_fifo.sv
// Small first-word-fall-through queue of registers.
// No dependencies; used between front and back end and on the result side.
module lefcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Storage for queued entries.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lefcr_front.sv
// Front end: accepts input items and converts pixels to Q8.8 luma.
// Depends on lefcr_pkg; the division by the luma denominator is a reciprocal multiply.
module lefcr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_kind,
  input  logic [7:0]           in_blue_in,
  input  logic [7:0]           in_green_in,
  input  logic [7:0]           in_red_in,
  output lefcr_pkg::pix_item_t item_o,
  output logic                 item_push,
  input  logic                 item_full
);

  import lefcr_pkg::*;

  fe_state_t   state_r, state_nxt;
  logic        kind_r;
  logic [23:0] color_r;
  logic [17:0] n_r;
  logic [29:0] y_r;
  logic [15:0] luma_r;

  logic [17:0] n_c;
  logic [29:0] y_c;
  logic [60:0] prod_c;
  logic [15:0] q_c;
  logic        accept;

  assign in_full = (state_r != FE_IDLE);
  assign accept  = in_push && !in_full;

  // Weighted color sum and scaled numerator.
  assign n_c = 18'(in_blue_in) * COEF_B + 18'(in_green_in) * COEF_G
             + 18'(in_red_in) * COEF_R;
  assign y_c = 30'(n_r) * LUMA_SCALE + LUMA_ROUND;

  // Quotient by multiplication with the scaled reciprocal.
  assign prod_c = 61'(y_r) * 61'(LUMA_RECIP);
  assign q_c    = prod_c[LUMA_SHIFT+15:LUMA_SHIFT];

  assign item_o    = '{kind: kind_r, color: color_r, luma: luma_r};
  assign item_push = (state_r == FE_PUSH) && !item_full;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind == KIND_DRAIN) ? FE_PUSH : FE_SCALE;
        end
      end
      FE_SCALE: state_nxt = FE_DIV;
      FE_DIV:   state_nxt = FE_PUSH;
      FE_PUSH: begin
        if (!item_full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          kind_r <= in_kind;
          n_r    <= n_c;
          if (in_kind == KIND_DRAIN) begin
            color_r <= '0;
            luma_r  <= '0;
          end else begin
            color_r <= {in_red_in, in_green_in, in_blue_in};
          end
        end
      end
      FE_SCALE: begin
        y_r <= y_c;
      end
      FE_DIV: begin
        luma_r <= LUMA_OFFSET + q_c;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/lefcr_back.sv
// Back end: line buffer access, 3x3 luma window, position tracking and LoG filter.
// Depends on lefcr_pkg; the line buffers are lefcr_ram instances in the top level.
module lefcr_back #(
  parameter int MAX_WIDTH  = lefcr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lefcr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lefcr_pkg::frame_cfg_t        cfg,
  input  lefcr_pkg::pix_item_t         item_i,
  input  logic                         item_empty,
  output logic                         item_pop,
  output logic [$clog2(MAX_WIDTH)-1:0] line_addr,
  input  logic [39:0]                  recent_rdata,
  input  logic [15:0]                  older_rdata,
  output logic                         line_we,
  output logic [39:0]                  recent_wdata,
  output logic [15:0]                  older_wdata,
  output lefcr_pkg::result_t           res_o,
  output logic                         res_push,
  input  logic                         res_full
);

  import lefcr_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int XA  = ((WB > HB) ? WB : HB) + 2;
  localparam int XW  = (XA > CFG_DATA_W + 1) ? XA : CFG_DATA_W + 1;

  be_state_t   state_r, state_nxt;
  pix_item_t   item_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [PW-1:0] pend_r;
  logic [15:0] lw_r [9];
  logic [23:0] cc_r;
  logic        fe_r;
  logic [17:0] csum_r, esum_r;
  logic [15:0] ctr_r;
  logic [31:0] pc_r;
  logic [28:0] pe_r;
  logic [30:0] pz_r;

  logic [XW-1:0] w_x, h_x, cw_x, ch_x;
  logic [XW-1:0] c_x, r_x, pend_x, cinc_x, rinc_x;
  logic [XW-1:0] col_nxt_x, row_nxt_x, pend_nxt_x;
  logic          drain, emit, in_region, start, drop;
  logic signed [33:0] sum_c;
  logic [33:0]   mag_c;
  logic [7:0]    m_c;

  // Geometry clamped to the supported range.
  assign cw_x = XW'(cfg.width);
  assign ch_x = XW'(cfg.height);
  assign w_x  = (cw_x < XW'(4)) ? XW'(4) : (cw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : cw_x;
  assign h_x  = (ch_x < XW'(4)) ? XW'(4) : (ch_x > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : ch_x;

  assign c_x    = XW'(col_r);
  assign r_x    = XW'(row_r);
  assign pend_x = XW'(pend_r);
  assign drain  = (item_r.kind == KIND_DRAIN);

  // Start a transfer only when the result queue can take its result.
  assign start = (state_r == BE_IDLE) && !item_empty && !res_full;
  assign drop  = (item_i.kind == KIND_DRAIN) && (pend_r == '0);
  assign item_pop = start;

  // Line buffers are addressed by the current column for the whole item.
  assign line_addr    = col_r;
  assign line_we      = (state_r == BE_UPDATE);
  assign recent_wdata = {item_r.luma, item_r.color};
  assign older_wdata  = recent_rdata[39:24];

  // Fill/drain accounting and position advance.
  always_comb begin
    emit       = 1'b1;
    pend_nxt_x = pend_x;
    if (drain) begin
      pend_nxt_x = pend_x - 1'b1;
    end else if (pend_x >= w_x + 1'b1) begin
      pend_nxt_x = w_x + 1'b1;
    end else begin
      emit       = 1'b0;
      pend_nxt_x = pend_x + 1'b1;
    end
    cinc_x    = c_x + 1'b1;
    rinc_x    = r_x + 1'b1;
    col_nxt_x = cinc_x;
    row_nxt_x = r_x;
    if (cinc_x >= w_x) begin
      col_nxt_x = '0;
      row_nxt_x = (rinc_x >= h_x) ? '0 : rinc_x;
    end
    if (drain && (pend_nxt_x == '0)) begin
      col_nxt_x = '0;
      row_nxt_x = '0;
    end
  end

  // The delayed center pixel sits one column and one row behind the input.
  assign in_region = (c_x >= XW'(1)) && (r_x >= XW'(1))
                  && ((c_x - 1'b1) >= (w_x >> 2))
                  && ((c_x - 1'b1) < ((w_x + (w_x << 1)) >> 2))
                  && ((r_x - 1'b1) >= (h_x >> 2))
                  && ((r_x - 1'b1) < ((h_x + (h_x << 1)) >> 2));

  // Final kernel sum, magnitude and saturation.
  assign sum_c = $signed({2'b00, pc_r}) - $signed({5'b0, pe_r}) - $signed({3'b000, pz_r});
  assign mag_c = sum_c[33] ? 34'(-sum_c) : 34'(sum_c);
  assign m_c   = (mag_c[33:22] > 12'd255) ? 8'hFF : mag_c[29:22];

  // Result selection.
  always_comb begin
    res_push = 1'b0;
    res_o    = '{frame_end: fe_r, red: m_c, green: m_c, blue: m_c};
    if (state_r == BE_UPDATE) begin
      res_push = emit && !in_region;
      res_o    = '{frame_end: (col_r == '0) && (row_r == '0),
                   red: cc_r[23:16], green: cc_r[15:8], blue: cc_r[7:0]};
    end else if (state_r == BE_OUT) begin
      res_push = 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: begin
        if (start && !drop) begin
          state_nxt = BE_UPDATE;
        end
      end
      BE_UPDATE: state_nxt = (emit && in_region) ? BE_SUM : BE_IDLE;
      BE_SUM:    state_nxt = BE_MUL;
      BE_MUL:    state_nxt = BE_OUT;
      BE_OUT:    state_nxt = BE_IDLE;
      default:   state_nxt = BE_IDLE;
    endcase
  end

  // Position, fill state, luma window and delayed center color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      cc_r   <= '0;
      for (int i = 0; i < 9; i++) begin
        lw_r[i] <= '0;
      end
    end else if (state_r == BE_UPDATE) begin
      col_r  <= col_nxt_x[CW-1:0];
      row_r  <= row_nxt_x[RW-1:0];
      pend_r <= pend_nxt_x[PW-1:0];
      cc_r   <= recent_rdata[23:0];
      for (int k = 0; k < 3; k++) begin
        lw_r[k*3]     <= lw_r[k*3 + 1];
        lw_r[k*3 + 1] <= lw_r[k*3 + 2];
      end
      lw_r[2] <= older_rdata;
      lw_r[5] <= recent_rdata[39:24];
      lw_r[8] <= item_r.luma;
    end
  end

  // Item capture and filter pipeline registers.
  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= item_i;
    end
    if (state_r == BE_UPDATE) begin
      fe_r <= (col_r == '0) && (row_r == '0);
    end
    if (state_r == BE_SUM) begin
      csum_r <= 18'(lw_r[0]) + 18'(lw_r[2]) + 18'(lw_r[6]) + 18'(lw_r[8]);
      esum_r <= 18'(lw_r[1]) + 18'(lw_r[3]) + 18'(lw_r[5]) + 18'(lw_r[7]);
      ctr_r  <= lw_r[4];
    end
    if (state_r == BE_MUL) begin
      pc_r <= 32'(csum_r) * 32'(K_CORNER);
      pe_r <= 29'(esum_r) * 29'(K_EDGE_MAG);
      pz_r <= 31'(ctr_r) * 31'(K_CENTER_MAG);
    end
  end

`ifndef SYNTHESIS
  // An empty pipeline always sits at the frame origin.
  a_origin_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> ((col_r == '0) && (row_r == '0)))
    else $error("pipeline empty away from frame origin");

  // A result is only produced when the result queue has room.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result transfer into a full queue");

  // The update step always follows the pop of its item.
  a_update_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_UPDATE) |-> $past(item_pop))
    else $error("update without a popped item");

  // The filter result is pushed in BE_OUT, after the BE_SUM and BE_MUL steps.
  a_filter_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_UPDATE && emit && in_region) |=> ##2 res_push)
    else $error("filter result not delivered on time");
`endif

endmodule

FILE: rtl/core/log_edge_filter_center_region_top.sv
// Top level of the LoG edge filter on the central half of a BGR stream.
// Depends on lefcr_pkg, lefcr_front, lefcr_fifo, lefcr_back and lefcr_ram.
//
// Usage:
//   Input channel: drive in_kind and the color ports with in_push high; the
//   item transfers on a clock edge where in_full is low. in_kind = 1 is a
//   drain item that pushes the pipeline without a new pixel.
//   Result channel: while out_empty is low the oldest result is on the out_
//   ports; it transfers on an edge where out_pop is high.
//   Configuration: write frame_width or frame_height with cfg_we, cfg_index
//   and cfg_data, only while the block is idle.
//   Steps: a pixel passes the front end through accept, numerator scaling,
//   reciprocal multiply and hand-off; a drain item skips to the hand-off.
//   The front end takes no new item before the hand-off. The back end takes
//   an update step per item, plus sum, multiply and output steps inside the
//   filter region. Results start after the fill of W+1 pixels.
//   Reset (rst_n low, synchronous) empties all queues, clears the window and
//   counters and loads width 640, height 480; line buffers are not cleared.
//   When the receiver stalls, two results wait in the output queue, then the
//   back end holds, the middle queue fills and in_full rises.
module log_edge_filter_center_region_top #(
  parameter int MAX_WIDTH  = lefcr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lefcr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lefcr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_kind,
  input  logic [7:0]                       in_blue_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_red_in,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [7:0]                       out_blue_out,
  output logic [7:0]                       out_green_out,
  output logic [7:0]                       out_red_out,
  output logic                             out_frame_end
);

  import lefcr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  frame_cfg_t cfg_r;
  pix_item_t  fe_item, be_item;
  logic       fe_push, mid_full, mid_empty, be_pop;
  result_t    res_in, res_out;
  logic       res_push, res_full;
  logic [CW-1:0] line_addr;
  logic [39:0] recent_rdata, recent_wdata;
  logic [15:0] older_rdata, older_wdata;
  logic        line_we;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RESET_FRAME_WIDTH;
      cfg_r.height <= RESET_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_FRAME_HEIGHT: cfg_r.height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lefcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_kind    (in_kind),
    .in_blue_in (in_blue_in),
    .in_green_in(in_green_in),
    .in_red_in  (in_red_in),
    .item_o     (fe_item),
    .item_push  (fe_push),
    .item_full  (mid_full)
  );

  // Queue between front and back end.
  lefcr_fifo #(
    .WIDTH($bits(pix_item_t)),
    .DEPTH(2)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fe_push),
    .din  (fe_item),
    .full (mid_full),
    .pop  (be_pop),
    .dout (be_item),
    .empty(mid_empty)
  );

  lefcr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_i      (be_item),
    .item_empty  (mid_empty),
    .item_pop    (be_pop),
    .line_addr   (line_addr),
    .recent_rdata(recent_rdata),
    .older_rdata (older_rdata),
    .line_we     (line_we),
    .recent_wdata(recent_wdata),
    .older_wdata (older_wdata),
    .res_o       (res_in),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  // Line holding color and luma of the previous row.
  lefcr_ram #(
    .WIDTH(40),
    .DEPTH(MAX_WIDTH)
  ) u_recent_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_addr),
    .wdata(recent_wdata),
    .raddr(line_addr),
    .rdata(recent_rdata)
  );

  // Line holding the luma of the row before that.
  lefcr_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_older_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_addr),
    .wdata(older_wdata),
    .raddr(line_addr),
    .rdata(older_rdata)
  );

  // Output queue decouples the receiver from the back end.
  lefcr_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_out),
    .empty(out_empty)
  );

  assign out_blue_out  = res_out.blue;
  assign out_green_out = res_out.green;
  assign out_red_out   = res_out.red;
  assign out_frame_end = res_out.frame_end;

endmodule

FILE: bench/edge_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard class for the LoG edge filter: a predictor of the block and the
// store of expected output pixels. Depends on nothing but the simulator.

typedef struct {
  bit [7:0] blue;
  bit [7:0] green;
  bit [7:0] red;
  bit       frame_end;
} out_pixel_t;

class edge_scoreboard;
  // Raw geometry registers, clamped on use.
  bit [11:0]   width_reg;
  bit [11:0]   height_reg;
  // Line stores: {luma, color} of the last line, luma of the line before it.
  bit [39:0]   recent_line [2048];
  bit [15:0]   older_line [2048];
  bit [15:0]   luma_win [9];
  bit [23:0]   center_color [2];
  int unsigned col;
  int unsigned row;
  int unsigned in_flight;
  out_pixel_t  expected_q [$];
  int          errors;

  function new();
    width_reg = 12'd640;
    height_reg = 12'd480;
    foreach (luma_win[i]) luma_win[i] = '0;
    center_color[0] = '0;
    center_color[1] = '0;
    col = 0;
    row = 0;
    in_flight = 0;
    errors = 0;
  endfunction

  function void set_geometry(bit [11:0] w, bit [11:0] h);
    width_reg = w;
    height_reg = h;
  endfunction

  // Accepted input transfer: update the predictor and queue any result.
  function void note_input(bit kind, bit [7:0] b, bit [7:0] g, bit [7:0] r);
    int unsigned w, h, c, rw, idx, m;
    bit [39:0]   old;
    bit [23:0]   color;
    bit [15:0]   luma;
    bit          emit;
    longint      n, corners, edges, s;
    longint unsigned mag;
    out_pixel_t  res;
    w = width_reg < 4 ? 4 : (width_reg > 2048 ? 2048 : width_reg);
    h = height_reg < 4 ? 4 : (height_reg > 2048 ? 2048 : height_reg);
    c = col;
    rw = row;
    idx = c < 2048 ? c : 2047;
    color = '0;
    luma = '0;
    // A drain item with nothing in flight is ignored.
    if (kind && in_flight == 0) return;
    if (!kind) begin
      color = {r, g, b};
      n = 114 * b + 587 * g + 299 * r;
      luma = 16'(4096 + (n * 56064 + 127500) / 255000);
    end
    // Shift the window and rotate the line stores.
    old = recent_line[idx];
    for (int k = 0; k < 3; k++) begin
      luma_win[k*3] = luma_win[k*3+1];
      luma_win[k*3+1] = luma_win[k*3+2];
    end
    luma_win[2] = older_line[idx];
    luma_win[5] = old[39:24];
    luma_win[8] = luma;
    center_color[0] = center_color[1];
    center_color[1] = old[23:0];
    older_line[idx] = old[39:24];
    recent_line[idx] = {luma, color};
    if (kind) begin
      emit = 1;
      in_flight--;
    end else if (in_flight >= w + 1) begin
      emit = 1;
      in_flight = w + 1;
    end else begin
      emit = 0;
      in_flight++;
    end
    if (emit) begin
      res.blue = center_color[0][7:0];
      res.green = center_color[0][15:8];
      res.red = center_color[0][23:16];
      if (c >= 1 && rw >= 1 && (c - 1) >= w / 4 && (c - 1) < (3 * w) / 4 &&
          (rw - 1) >= h / 4 && (rw - 1) < (3 * h) / 4) begin
        corners = longint'(luma_win[0]) + luma_win[2] + luma_win[6] + luma_win[8];
        edges = longint'(luma_win[1]) + luma_win[3] + luma_win[5] + luma_win[7];
        s = corners * 8058 - edges * 1880 - longint'(luma_win[4]) * 24712;
        mag = s < 0 ? -s : s;
        mag = mag >> 22;
        m = mag > 255 ? 255 : 32'(mag);
        res.blue = 8'(m);
        res.green = 8'(m);
        res.red = 8'(m);
      end
      res.frame_end = (c == 0 && rw == 0);
      expected_q.push_back(res);
    end
    // Advance the raster position; a full drain starts a new frame.
    c++;
    if (c >= w) begin
      c = 0;
      rw++;
      if (rw >= h) rw = 0;
    end
    if (kind && in_flight == 0) begin
      c = 0;
      rw = 0;
    end
    col = c;
    row = rw;
  endfunction

  // Accepted output transfer: compare with the oldest expected pixel.
  function void check_result(out_pixel_t got);
    out_pixel_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected output pixel b=%0d g=%0d r=%0d end=%0d", $time,
               got.blue, got.green, got.red, got.frame_end);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.blue != want.blue) begin
      $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
      errors++;
    end
    if (got.green != want.green) begin
      $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
      errors++;
    end
    if (got.red != want.red) begin
      $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
      errors++;
    end
    if (got.frame_end != want.frame_end) begin
      $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
               got.frame_end);
      errors++;
    end
  endfunction
endclass

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the LoG edge filter testbench: clock, reset, stimulus and output sink.
// Depends on lefcr_pkg, the block's RTL and edge_scoreboard.sv.
module tb_top;
  import lefcr_pkg::*;

  localparam int LIMIT = 1000000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic       cfg_index = 0;
  logic [11:0] cfg_data = 0;
  logic       in_push = 0;
  logic       in_kind = 0;
  logic [7:0] in_blue_in = 0;
  logic [7:0] in_green_in = 0;
  logic [7:0] in_red_in = 0;
  logic       out_pop = 0;
  logic       in_full, out_empty, out_frame_end;
  logic [7:0] out_blue_out, out_green_out, out_red_out;

  edge_scoreboard board = new();
  int unsigned tx_idle = 32;
  int unsigned rx_idle = 53;
  int unsigned pixels_sent = 0;
  int unsigned cycles = 0;
  bit push_on = 0;
  bit paused_once = 0;

  log_edge_filter_center_region_top dut (.*);

  always #10 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("log_edge_filter_center_region_top test failed");
      $finish;
    end
  end

  // Output side: check each transfer, then stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (out_pop && !out_empty)
        board.check_result('{out_blue_out, out_green_out, out_red_out, out_frame_end});
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Set the idling mix from how far the random part has come.
  function automatic void update_idling();
    if (pixels_sent < 133) begin
      tx_idle = 32;
      rx_idle = 53;
    end else if (pixels_sent < 266) begin
      tx_idle = 53;
      rx_idle = 32;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endfunction

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic stop_push();
    if (push_on) begin
      in_push <= 0;
      push_on = 0;
    end
  endtask

  // Offer one item and hold it until the transfer, then maybe idle.
  task automatic push_item(bit kind, bit [7:0] b, bit [7:0] g, bit [7:0] r);
    in_push <= 1;
    push_on = 1;
    in_kind <= kind;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    do @(posedge clk); while (in_full);
    board.note_input(kind, b, g, r);
    if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
      stop_push();
      repeat ($urandom_range(1, $urandom_range(3) == 0 ? 25 : 3)) @(posedge clk);
    end
  endtask

  // Flush the pipeline, then wait until the block is quiet.
  task automatic drain_and_settle();
    while (board.in_flight > 0)
      push_item(KIND_DRAIN, pick_byte(), pick_byte(), pick_byte());
    stop_push();
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_geometry(bit [11:0] w, bit [11:0] h);
    cfg_we <= 1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 0;
    board.set_geometry(w, h);
  endtask

  // One stream at a given geometry with random content and some drains.
  task automatic run_stream(bit [11:0] w, bit [11:0] h, int unsigned npix);
    write_geometry(w, h);
    for (int i = 0; i < npix; i++) begin
      if (board.in_flight > 0 && $urandom_range(99) < 6) begin
        push_item(KIND_DRAIN, pick_byte(), pick_byte(), pick_byte());
      end else begin
        push_item(KIND_PIXEL, pick_byte(), pick_byte(), pick_byte());
        pixels_sent++;
        update_idling();
      end
      // Once, hold the input until every expected pixel has arrived.
      if (!paused_once && pixels_sent > 60 && i == npix / 2) begin
        paused_once = 1;
        stop_push();
        while (board.expected_q.size() != 0) @(posedge clk);
      end
    end
    drain_and_settle();
  endtask

  initial begin
    bit [11:0] w, h;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Drain items with an empty pipeline do nothing.
    push_item(KIND_DRAIN, 8'hff, 8'hff, 8'hff);
    push_item(KIND_DRAIN, 8'h00, 8'h00, 8'h00);
    stop_push();
    repeat (60) @(posedge clk);

    // Directed: smallest frame (zero clamps to four), color extremes,
    // and a drain in the middle of the frame.
    write_geometry(12'd0, 12'd0);
    for (int i = 0; i < 20; i++) begin
      if (i == 12)
        push_item(KIND_DRAIN, 8'h55, 8'haa, 8'h55);
      else
        push_item(KIND_PIXEL, i[0] ? 8'hff : 8'h00, i[1] ? 8'hff : 8'h00,
                  i[2] ? 8'hff : 8'h00);
    end
    drain_and_settle();

    // Wider line with the shortest frame (height clamps to four).
    run_stream(12'd48, 12'd3, 120);

    // Random geometries, mostly small frames.
    while (pixels_sent < 400) begin
      case ($urandom_range(9))
        0: w = 12'($urandom_range(0, 3));
        1: w = 12'($urandom_range(13, 40));
        default: w = 12'($urandom_range(4, 12));
      endcase
      case ($urandom_range(9))
        0: h = 12'($urandom_range(0, 3));
        1: h = 12'd2048;
        default: h = 12'($urandom_range(4, 12));
      endcase
      run_stream(w, h, $urandom_range(8, 120));
    end
    write_geometry(12'd640, 12'd480);

    if (board.errors == 0)
      $display("log_edge_filter_center_region_top test passed");
    else
      $display("log_edge_filter_center_region_top test failed");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/lefcr_pkg.sv
rtl/core/lefcr_ram.sv
rtl/core/lefcr_fifo.sv
rtl/core/lefcr_front.sv
rtl/core/lefcr_back.sv
rtl/core/log_edge_filter_center_region_top.sv
bench/edge_scoreboard.sv
bench/tb_top.sv
